// ===== src/gecf_pkg.sv =====
`timescale 1ns / 1ps

package gecf_pkg;

  // configuration register map, word index on paddr[3:2]
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_GRAY_SHADE     = 2'd2;
  localparam logic [1:0] REG_SPAN_TOLERANCE = 2'd3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] frame_width;
    logic [7:0] frame_height;
    logic [7:0] gray_shade;
    logic [7:0] span_tolerance;
  } cfg_t;

  // end-of-frame job handed from front to back
  typedef struct packed {
    logic [31:0] index_sum;
    logic [15:0] match_count;
    logic [7:0]  width;
    logic        ok;
  } job_t;

endpackage

// ===== src/gecf_fifo.sv =====
`timescale 1ns / 1ps

module gecf_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  gecf_pkg::job_t              push_job,
  input  logic                        pop,
  output gecf_pkg::job_t              pop_job,
  output logic [gecf_pkg::FIFO_CW-1:0] count
);
  import gecf_pkg::*;

  job_t               slot_r [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_r;
  logic [FIFO_PW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  assign pop_job = slot_r[rd_ptr_r];
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/gecf_front.sv =====
`timescale 1ns / 1ps

module gecf_front #(
  parameter int MAX_WIDTH  = 255,
  parameter int MAX_HEIGHT = 255
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gecf_pkg::cfg_t               cfg,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] pixel_gray
  input  logic [gecf_pkg::FIFO_CW-1:0] q_count,
  output logic                         push,
  output gecf_pkg::job_t               push_job
);
  import gecf_pkg::*;

  localparam int         CW      = $clog2(MAX_WIDTH);
  localparam logic [7:0] MAX_W8  = 8'(MAX_WIDTH);
  localparam logic [7:0] MAX_H8  = 8'(MAX_HEIGHT);

  logic [7:0]  col_r, row_r;
  logic [15:0] lin_r;
  logic        has_r;
  logic [7:0]  first_r;
  logic [7:0]  wide_r;
  logic [31:0] sum_r;
  logic [15:0] cnt_r;
  logic [MAX_WIDTH-1:0] seen_r;
  logic [7:0]  first_row_mem [MAX_WIDTH];
  logic [7:0]  rd_r;

  // second stage: column span check against the stored first row
  logic        s2_valid_r, s2_last_r, s2_chk_r;
  logic [7:0]  s2_row_r;
  logic [31:0] s2_sum_r;
  logic [15:0] s2_cnt_r;
  logic [7:0]  s2_wide_r, s2_w_r;
  logic [7:0]  tall_r;

  logic [7:0]  w_eff, h_eff;
  logic        row_end, frame_end, acc, marked, was_seen;
  logic [CW-1:0] cidx;
  logic        has_nxt;
  logic [7:0]  first_nxt, wide_nxt, row_span;
  logic [31:0] sum_nxt;
  logic [15:0] cnt_nxt;
  logic [7:0]  col_span, tall_nxt, span_diff;
  logic        pend, room;

  always_comb begin
    w_eff = (cfg.frame_width == 8'd0) ? 8'd1 : cfg.frame_width;
    if (w_eff > MAX_W8) w_eff = MAX_W8;
    h_eff = (cfg.frame_height == 8'd0) ? 8'd1 : cfg.frame_height;
    if (h_eff > MAX_H8) h_eff = MAX_H8;
  end

  assign row_end   = ({1'b0, col_r} + 9'd1) >= {1'b0, w_eff};
  assign frame_end = row_end && (({1'b0, row_r} + 9'd1) >= {1'b0, h_eff});

  // a frame's last word needs a free queue slot, counting the job still in stage two
  assign pend      = s2_valid_r && s2_last_r;
  assign room      = ((FIFO_CW+1)'(q_count) + (FIFO_CW+1)'(pend)) < (FIFO_CW+1)'(FIFO_DEPTH);
  assign in_tready = !frame_end || room;
  assign acc       = in_tvalid && in_tready;
  assign marked    = in_tdata == cfg.gray_shade;
  assign cidx      = col_r[CW-1:0];
  assign was_seen  = seen_r[cidx];

  always_comb begin
    has_nxt   = has_r;
    first_nxt = first_r;
    wide_nxt  = wide_r;
    row_span  = col_r - first_r;
    if (marked) begin
      if (!has_r) begin
        has_nxt   = 1'b1;
        first_nxt = col_r;
      end else if (col_r >= first_r && row_span > wide_r) begin
        wide_nxt = row_span;
      end
    end
    sum_nxt = sum_r + (marked ? {16'd0, lin_r} : 32'd0);
    cnt_nxt = cnt_r + {15'd0, marked};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      lin_r   <= '0;
      has_r   <= 1'b0;
      first_r <= '0;
      wide_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      seen_r  <= '0;
    end else if (acc) begin
      col_r   <= row_end ? 8'd0 : col_r + 8'd1;
      row_r   <= frame_end ? 8'd0 : (row_end ? row_r + 8'd1 : row_r);
      lin_r   <= frame_end ? 16'd0 : lin_r + 16'd1;
      has_r   <= row_end ? 1'b0 : has_nxt;
      first_r <= row_end ? 8'd0 : first_nxt;
      wide_r  <= frame_end ? 8'd0 : wide_nxt;
      sum_r   <= frame_end ? 32'd0 : sum_nxt;
      cnt_r   <= frame_end ? 16'd0 : cnt_nxt;
      if (frame_end) begin
        seen_r <= '0;
      end else if (marked) begin
        seen_r[cidx] <= 1'b1;
      end
    end
  end

  // first marked row per column; only read where the seen bit is set
  always_ff @(posedge clk) begin
    if (acc && marked && !was_seen) begin
      first_row_mem[cidx] <= row_r;
    end
    rd_r <= first_row_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_last_r  <= 1'b0;
    end else begin
      s2_valid_r <= acc;
      if (acc) s2_last_r <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_chk_r  <= marked && was_seen;
      s2_row_r  <= row_r;
      s2_sum_r  <= sum_nxt;
      s2_cnt_r  <= cnt_nxt;
      s2_wide_r <= wide_nxt;
      s2_w_r    <= w_eff;
    end
  end

  always_comb begin
    col_span = s2_row_r - rd_r;
    tall_nxt = tall_r;
    if (s2_valid_r && s2_chk_r && s2_row_r >= rd_r && col_span > tall_r) begin
      tall_nxt = col_span;
    end
    span_diff = (s2_wide_r >= tall_nxt) ? s2_wide_r - tall_nxt : tall_nxt - s2_wide_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_r <= '0;
    end else begin
      tall_r <= pend ? 8'd0 : tall_nxt;
    end
  end

  assign push                 = pend;
  assign push_job.index_sum   = s2_sum_r;
  assign push_job.match_count = s2_cnt_r;
  assign push_job.width       = s2_w_r;
  assign push_job.ok          = (s2_cnt_r != 16'd0) && (span_diff <= cfg.span_tolerance);

endmodule

// ===== src/gecf_div.sv =====
`timescale 1ns / 1ps

module gecf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [15:0] remainder
);

  // restoring divider, one quotient bit a cycle
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r, dv_r;
  logic [16:0] trial, diff;
  logic        ge;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dv_r};
  assign ge    = trial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[30:0], ge};
      rem_r <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== src/gecf_back.sv =====
`timescale 1ns / 1ps

module gecf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [gecf_pkg::FIFO_CW-1:0] q_count,
  input  gecf_pkg::job_t               job,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [7:0] center_x, [15:8] center_y
  output logic                         out_tuser   // [0] gate_found
);
  import gecf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MEAN = 4'b0010,
    S_COL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  w_r, cx_r, cy_r;
  logic        fnd_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_user_r;

  logic        div_start, div_done;
  logic [31:0] div_dividend, div_quo;
  logic [15:0] div_divisor, div_rem;
  logic        load_out;

  gecf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign load_out = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // mean = sum / count first, then mean split into column and row by the width
  always_comb begin
    state_nxt    = state_r;
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = job.index_sum;
    div_divisor  = job.match_count;
    case (state_r)
      S_IDLE: begin
        if (q_count != '0) begin
          pop = 1'b1;
          if (job.ok) begin
            div_start = 1'b1;
            state_nxt = S_MEAN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_MEAN: begin
        div_dividend = {16'd0, div_quo[15:0]};
        div_divisor  = {8'd0, w_r};
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_r   <= job.width;
      fnd_r <= job.ok;
      cx_r  <= '0;
      cy_r  <= '0;
    end else if (state_r == S_COL && div_done) begin
      cx_r <= div_rem[7:0];
      cy_r <= div_quo[7:0];
    end
    if (load_out) begin
      out_data_r <= {cy_r, cx_r};
      out_user_r <= fnd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== src/gate_extent_centroid_finder.sv =====
`timescale 1ns / 1ps

// Gate extent and centroid finder. Pixels of a gray frame stream in raster order, one
// word a cycle. Pixels equal to the shade register are marked; the widest row span, the
// tallest column span (per-column first-row memory, read in the cycle after the word),
// and the sum and count of marked indices are gathered on the fly. The frame's last
// pixel queues one job in a two-entry queue; the back end then runs a shared 32-step
// restoring divider twice (mean = sum/count, then mean by width); a job in which
// nothing matched or the spans disagree skips the divider. The input stalls only on a
// frame's last pixel, when the queue, counting a job still in the front end's second
// stage, has no free entry. No clearing pass is needed after reset.

module gate_extent_centroid_finder #(
  parameter int MAX_WIDTH  = 255,
  parameter int MAX_HEIGHT = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel_gray
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] center_x, [15:8] center_y
  output logic        out_tuser,   // [0] gate_found
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gecf_pkg::*;

  logic [7:0] frame_width_r, frame_height_r, gray_shade_r, span_tolerance_r;
  cfg_t       cfg;
  logic       cfg_wr;

  logic               q_push, q_pop;
  job_t               q_push_job, q_pop_job;
  logic [FIFO_CW-1:0] q_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= 8'd255;
      frame_height_r   <= 8'd255;
      gray_shade_r     <= 8'd0;
      span_tolerance_r <= 8'd8;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_pwdata[7:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_pwdata[7:0];
        REG_GRAY_SHADE:     gray_shade_r     <= cfg_pwdata[7:0];
        REG_SPAN_TOLERANCE: span_tolerance_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FRAME_WIDTH:    cfg_prdata = {24'd0, frame_width_r};
      REG_FRAME_HEIGHT:   cfg_prdata = {24'd0, frame_height_r};
      REG_GRAY_SHADE:     cfg_prdata = {24'd0, gray_shade_r};
      REG_SPAN_TOLERANCE: cfg_prdata = {24'd0, span_tolerance_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.frame_width    = frame_width_r;
  assign cfg.frame_height   = frame_height_r;
  assign cfg.gray_shade     = gray_shade_r;
  assign cfg.span_tolerance = span_tolerance_r;

  gecf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_count   (q_count),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  gecf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .count    (q_count)
  );

  gecf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_count    (q_count),
    .job        (q_pop_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
